// ===== rtl/phfu_pkg.sv =====
// Shared types and constants for the pipeline hazard and forwarding unit.
`timescale 1ns / 1ps

package phfu_pkg;

  // Register index width and the index that marks "no register".
  localparam int unsigned REG_INDEX_BITS = 6;
  localparam logic [REG_INDEX_BITS-1:0] NONE_REG = REG_INDEX_BITS'(63);

  // Configuration register indexes.
  localparam int unsigned CFG_INDEX_BITS = 2;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_MEM_EX  = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_EX_EX   = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_MEM_MEM = 2'd2;

  // Operand bypass selections.
  localparam logic [1:0] SEL_NONE = 2'd0;
  localparam logic [1:0] SEL_EX   = 2'd1;
  localparam logic [1:0] SEL_MEM  = 2'd2;

  // Store data bypass selections.
  localparam logic [1:0] ST_NONE    = 2'd0;
  localparam logic [1:0] ST_EX_EX   = 2'd1;
  localparam logic [1:0] ST_MEM_EX  = 2'd2;
  localparam logic [1:0] ST_MEM_MEM = 2'd3;

  // Flag bit positions of the EX and MEM stage flag fields.
  localparam int unsigned FLAG_INT = 0;
  localparam int unsigned FLAG_FP  = 1;
  localparam int unsigned FLAG_LO  = 2;
  localparam int unsigned FLAG_HI  = 3;
  localparam int unsigned FLAG_MEM = 4;

  // One input item as captured in the input register.
  typedef struct packed {
    logic [REG_INDEX_BITS-1:0] src_a;
    logic [REG_INDEX_BITS-1:0] src_b;
    logic [REG_INDEX_BITS-1:0] dest_reg;
    logic                      reads_hi;
    logic                      reads_lo;
    logic                      fp_source;
    logic                      is_mem_op;
    logic [REG_INDEX_BITS-1:0] ex_dest;
    logic [4:0]                ex_flags;
    logic [REG_INDEX_BITS-1:0] mem_dest;
    logic [3:0]                mem_flags;
  } item_t;

  // One result item as held in the result register.
  typedef struct packed {
    logic       stall_res;
    logic [1:0] src_a_bypass;
    logic       src_a_from_hi;
    logic [1:0] src_b_bypass;
    logic [1:0] store_bypass;
  } result_t;

  // A register takes part in a match only when it is nonzero and not the "no register" mark.
  function automatic logic usable(input logic [REG_INDEX_BITS-1:0] r);
    usable = (r != '0) && (r != NONE_REG);
  endfunction

endpackage

// ===== rtl/pipeline_hazard_forward_unit.sv =====
// Top level of the pipeline hazard and forwarding unit.
`timescale 1ns / 1ps

// The unit judges one decoding instruction per item: it compares the source
// and store-data registers with the EX-stage and MEM-stage destinations and
// returns a stall request plus bypass selections. The checks run in the order
// MEM-EX, EX-EX, MEM-MEM, load-use, and a later selection overrides an earlier
// one; each bypass class either forwards or stalls as its enable bit says,
// while a load-use hazard always stalls. An accepted item is loaded into the
// input register, and its result then goes into the result register, which drives
// the outputs; a stall on the output side holds the result register and, once it is
// full, the input register. A new item is accepted every cycle as long as the output side keeps taking results.
// The three enable bits reset to 1 and are written through the plain configuration
// port; write them only while the unit is idle, as the block does not enforce it.
module pipeline_hazard_forward_unit import phfu_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // Configuration write port.
  input  logic                      cfg_we_i,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index_i,
  input  logic                      cfg_data_i,
  // Input channel.
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [REG_INDEX_BITS-1:0] src_a_i,
  input  logic [REG_INDEX_BITS-1:0] src_b_i,
  input  logic [REG_INDEX_BITS-1:0] dest_reg_i,
  input  logic                      reads_hi_i,
  input  logic                      reads_lo_i,
  input  logic                      fp_source_i,
  input  logic                      is_mem_op_i,
  input  logic [REG_INDEX_BITS-1:0] ex_dest_i,
  input  logic [4:0]                ex_flags_i,
  input  logic [REG_INDEX_BITS-1:0] mem_dest_i,
  input  logic [3:0]                mem_flags_i,
  // Output channel.
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic                      stall_res_o,
  output logic [1:0]                src_a_bypass_o,
  output logic                      src_a_from_hi_o,
  output logic [1:0]                src_b_bypass_o,
  output logic [1:0]                store_bypass_o
);

  logic    mem_ex_on_q, ex_ex_on_q, mem_mem_on_q;
  logic    in_valid_q, out_valid_q;
  item_t   item_q;
  result_t res_q, res_d;
  logic    out_ready, in_ready, in_accept;

  // Handshake: the result register moves when empty or taken, the input register
  // moves when empty or when its item moves on.
  assign out_ready  = !out_valid_q || !out_stall_i;
  assign in_ready   = !in_valid_q || out_ready;
  assign in_stall_o = !in_ready;
  assign in_accept  = in_valid_i && in_ready;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mem_ex_on_q  <= 1'b1;
      ex_ex_on_q   <= 1'b1;
      mem_mem_on_q <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_MEM_EX:  mem_ex_on_q  <= cfg_data_i;
        CFG_EX_EX:   ex_ex_on_q   <= cfg_data_i;
        CFG_MEM_MEM: mem_mem_on_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Valid bits of the two register stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready) begin
        in_valid_q <= in_valid_i;
      end
      if (out_ready) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      item_q <= '{src_a: src_a_i, src_b: src_b_i, dest_reg: dest_reg_i,
                  reads_hi: reads_hi_i, reads_lo: reads_lo_i,
                  fp_source: fp_source_i, is_mem_op: is_mem_op_i,
                  ex_dest: ex_dest_i, ex_flags: ex_flags_i,
                  mem_dest: mem_dest_i, mem_flags: mem_flags_i};
    end
    if (out_ready && in_valid_q) begin
      res_q <= res_d;
    end
  end

  // Hazard checks in priority order; later assignments override earlier ones.
  always_comb begin
    logic       a_ok, b_ok, d_ok;
    logic       x_int, x_fp, x_lo, x_hi, x_mem;
    logic       m_int, m_fp, m_lo, m_hi;
    logic       a_eq_x, b_eq_x, d_eq_x, a_eq_m, b_eq_m, d_eq_m;
    logic       stall, ahi;
    logic [1:0] sa, sb, st;

    a_ok   = usable(item_q.src_a);
    b_ok   = usable(item_q.src_b);
    d_ok   = usable(item_q.dest_reg);
    x_int  = item_q.ex_flags[FLAG_INT];
    x_fp   = item_q.ex_flags[FLAG_FP];
    x_lo   = item_q.ex_flags[FLAG_LO];
    x_hi   = item_q.ex_flags[FLAG_HI];
    x_mem  = item_q.ex_flags[FLAG_MEM];
    m_int  = item_q.mem_flags[FLAG_INT];
    m_fp   = item_q.mem_flags[FLAG_FP];
    m_lo   = item_q.mem_flags[FLAG_LO];
    m_hi   = item_q.mem_flags[FLAG_HI];
    a_eq_x = a_ok && (item_q.src_a == item_q.ex_dest);
    b_eq_x = b_ok && (item_q.src_b == item_q.ex_dest);
    d_eq_x = d_ok && (item_q.dest_reg == item_q.ex_dest);
    a_eq_m = a_ok && (item_q.src_a == item_q.mem_dest);
    b_eq_m = b_ok && (item_q.src_b == item_q.mem_dest);
    d_eq_m = d_ok && (item_q.dest_reg == item_q.mem_dest);
    stall  = 1'b0;
    ahi    = 1'b0;
    sa     = SEL_NONE;
    sb     = SEL_NONE;
    st     = ST_NONE;

    // MEM-EX class: forward from the older MEM-stage instruction.
    if (m_int && a_eq_m) begin
      if (mem_ex_on_q) begin sa = SEL_MEM; ahi = 1'b0; end else stall = 1'b1;
    end
    if (m_int && b_eq_m) begin
      if (mem_ex_on_q) sb = SEL_MEM; else stall = 1'b1;
    end
    if (m_int && d_eq_m && item_q.is_mem_op) begin
      if (mem_ex_on_q) st = ST_MEM_EX; else stall = 1'b1;
    end
    if (item_q.fp_source && m_fp && a_eq_m) begin
      if (mem_ex_on_q) begin sa = SEL_MEM; ahi = 1'b0; end else stall = 1'b1;
    end
    if (item_q.reads_lo && m_lo) begin
      if (mem_ex_on_q) begin sa = SEL_MEM; ahi = 1'b0; end else stall = 1'b1;
    end
    if (item_q.reads_hi && m_hi) begin
      if (mem_ex_on_q) begin sa = SEL_MEM; ahi = 1'b1; end else stall = 1'b1;
    end

    // EX-EX class: forward from the EX-stage instruction.
    if (x_int && a_eq_x && !x_mem) begin
      if (ex_ex_on_q) begin sa = SEL_EX; ahi = 1'b0; end else stall = 1'b1;
    end
    if (x_int && b_eq_x && !x_mem) begin
      if (ex_ex_on_q) sb = SEL_EX; else stall = 1'b1;
    end
    if (x_int && d_eq_x && !x_mem && item_q.is_mem_op) begin
      if (ex_ex_on_q) st = ST_EX_EX; else stall = 1'b1;
    end
    if (item_q.fp_source && x_fp && a_eq_x) begin
      if (ex_ex_on_q) begin sa = SEL_EX; ahi = 1'b0; end else stall = 1'b1;
    end
    if (item_q.reads_lo && x_lo) begin
      if (ex_ex_on_q) begin sa = SEL_EX; ahi = 1'b0; end else stall = 1'b1;
    end
    if (item_q.reads_hi && x_hi) begin
      if (ex_ex_on_q) begin sa = SEL_EX; ahi = 1'b1; end else stall = 1'b1;
    end

    // MEM-MEM class: store data from a memory operation in EX.
    if ((x_int || x_fp) && x_mem && item_q.is_mem_op && d_eq_x) begin
      if (mem_mem_on_q) st = ST_MEM_MEM; else stall = 1'b1;
    end

    // Load-use hazard always stalls.
    if ((x_int || x_fp) && x_mem && (a_eq_x || b_eq_x)) begin
      stall = 1'b1;
    end

    res_d.stall_res     = stall;
    res_d.src_a_bypass  = sa;
    res_d.src_a_from_hi = ahi && (sa != SEL_NONE);
    res_d.src_b_bypass  = sb;
    res_d.store_bypass  = st;
  end

  // Outputs straight from the result register.
  assign out_valid_o     = out_valid_q;
  assign stall_res_o     = res_q.stall_res;
  assign src_a_bypass_o  = res_q.src_a_bypass;
  assign src_a_from_hi_o = res_q.src_a_from_hi;
  assign src_b_bypass_o  = res_q.src_b_bypass;
  assign store_bypass_o  = res_q.store_bypass;

endmodule
